/* rtl/mas_pkg.sv */
// Package: shared constants and types for the modular add/sub/mul unit.
package mas_pkg;

   localparam int DATA_BITS            = 64;
   localparam int MODE_BITS            = 2;
   localparam int OPERAND_BITS_DEFAULT = 64;
   localparam logic [DATA_BITS-1:0] MODULUS_RESET = 64'd2;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_ADD = 2'd0,
      MODE_SUB = 2'd1,
      MODE_MUL = 2'd2
   } mode_type;

   typedef struct packed {
      logic     valid;
      mode_type mode;
   } ctrl_type;

endpackage

/* rtl/mas_req_if.sv */
// Interface: request channel carrying mode and two operands.
interface mas_req_if;
   import mas_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [MODE_BITS-1:0]         mode;
   logic [DATA_BITS-1:0]         operand_a;
   logic [DATA_BITS-1:0]         operand_b;

   modport source (output valid, mode, operand_a, operand_b, input ready);
   modport sink   (input valid, mode, operand_a, operand_b, output ready);
endinterface

/* rtl/mas_rsp_if.sv */
// Interface: response channel carrying one result.
interface mas_rsp_if;
   import mas_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [DATA_BITS-1:0] result;

   modport source (output valid, result, input ready);
   modport sink   (input valid, result, output ready);
endinterface

/* rtl/mas_reduce_stage.sv */
// One restoring-reduction step: folds one bit of the value into acc mod p.
module mas_reduce_stage #(
   parameter int N       = 64,
   parameter int BIT_POS = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic [N-1:0]      modulus,
   input  mas_pkg::ctrl_type ctrl_in,
   input  logic [N-1:0]      a_in,
   input  logic [N:0]        x_in,
   input  logic [N-1:0]      acc_in,
   input  logic [N-1:0]      misc_in,
   output mas_pkg::ctrl_type ctrl_out,
   output logic [N-1:0]      a_out,
   output logic [N:0]        x_out,
   output logic [N-1:0]      acc_out,
   output logic [N-1:0]      misc_out
);
   import mas_pkg::*;

   ctrl_type     ctrl_ff;
   logic [N-1:0] a_ff, acc_ff, misc_ff, acc_in_w;
   logic [N:0]   x_ff, t;

   always_comb begin
      t = {acc_in, x_in[BIT_POS]};
      if ((modulus != '0) && (t >= {1'b0, modulus})) begin
         t = t - {1'b0, modulus};
      end
      acc_in_w = t[N-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else if (enable) begin
         ctrl_ff.valid <= ctrl_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ctrl_ff.mode <= ctrl_in.mode;
         a_ff         <= a_in;
         x_ff         <= x_in;
         acc_ff       <= acc_in_w;
         misc_ff      <= misc_in;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign a_out    = a_ff;
   assign x_out    = x_ff;
   assign acc_out  = acc_ff;
   assign misc_out = misc_ff;
endmodule

/* rtl/mas_mul_stage.sv */
// Half of one interleaved multiply step: double mod p, or add b mod p.
module mas_mul_stage #(
   parameter int N       = 64,
   parameter int BIT_POS = 0,
   parameter bit HALF    = 1'b0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic [N-1:0]      modulus,
   input  mas_pkg::ctrl_type ctrl_in,
   input  logic [N-1:0]      a_in,
   input  logic [N-1:0]      b_in,
   input  logic [N-1:0]      acc_in,
   input  logic [N-1:0]      misc_in,
   output mas_pkg::ctrl_type ctrl_out,
   output logic [N-1:0]      a_out,
   output logic [N-1:0]      b_out,
   output logic [N-1:0]      acc_out,
   output logic [N-1:0]      misc_out
);
   import mas_pkg::*;

   ctrl_type     ctrl_ff;
   logic [N-1:0] a_ff, b_ff, acc_ff, misc_ff, acc_in_w;
   logic [N:0]   t;

   always_comb begin
      if (HALF) begin
         t = {1'b0, acc_in} + (a_in[BIT_POS] ? {1'b0, b_in} : '0);
      end else begin
         t = {acc_in, 1'b0};
      end
      if ((modulus != '0) && (t >= {1'b0, modulus})) begin
         t = t - {1'b0, modulus};
      end
      acc_in_w = t[N-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else if (enable) begin
         ctrl_ff.valid <= ctrl_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ctrl_ff.mode <= ctrl_in.mode;
         a_ff         <= a_in;
         b_ff         <= b_in;
         acc_ff       <= acc_in_w;
         misc_ff      <= misc_in;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign a_out    = a_ff;
   assign b_out    = b_ff;
   assign acc_out  = acc_ff;
   assign misc_out = misc_ff;
endmodule

/* rtl/modular_add_sub_mul_unit_top.sv */
// Top level: pipelined modular add, subtract and multiply over a set modulus.
// Takes one request per clock while not stalled and returns one result per request, in order.
// The pipe has one entry stage, OPERAND_BITS+1 restoring-reduction stages that bring
// the sum (add) or operand b (multiply) below p, 2*OPERAND_BITS interleaved multiply
// stages (one double-mod-p and one add-mod-p per bit of a) and the output register.
// The whole pipe stalls only while a result waits with rsp ready low.
// Write the modulus only while the unit is empty; modulus 0 means no reduction.
module modular_add_sub_mul_unit_top #(
   parameter int OPERAND_BITS = mas_pkg::OPERAND_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [mas_pkg::DATA_BITS-1:0] csr_wr_data,
   mas_req_if.sink                       req_chan,
   mas_rsp_if.source                     rsp_chan
);
   import mas_pkg::*;

   localparam int N = OPERAND_BITS;
   localparam int R = N + 1;
   localparam int M = 2 * N;

   logic [DATA_BITS-1:0] modulus_ff;
   logic [N-1:0]         p;
   logic                 enable;

   ctrl_type     r_ctrl [R+1];
   logic [N-1:0] r_a    [R+1];
   logic [N:0]   r_x    [R+1];
   logic [N-1:0] r_acc  [R+1];
   logic [N-1:0] r_misc [R+1];

   ctrl_type     m_ctrl [M+1];
   logic [N-1:0] m_a    [M+1];
   logic [N-1:0] m_b    [M+1];
   logic [N-1:0] m_acc  [M+1];
   logic [N-1:0] m_misc [M+1];

   ctrl_type     ent_ctrl_in;
   logic [N-1:0] op_a, op_b, sub_in;
   logic [N:0]   x_in;

   logic                 rsp_valid_ff;
   logic [DATA_BITS-1:0] rsp_result_ff, rsp_result_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_RESET;
      end else if (csr_wr_en) begin
         modulus_ff <= csr_wr_data;
      end
   end

   assign p              = modulus_ff[N-1:0];
   assign enable         = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = enable;

   // entry stage
   always_comb begin
      op_a              = req_chan.operand_a[N-1:0];
      op_b              = req_chan.operand_b[N-1:0];
      ent_ctrl_in.valid = req_chan.valid;
      ent_ctrl_in.mode  = mode_type'(req_chan.mode);
      if (ent_ctrl_in.mode == MODE_ADD) begin
         x_in = {1'b0, op_a} + {1'b0, op_b};
      end else begin
         x_in = {1'b0, op_b};
      end
      if (op_a < op_b) begin
         sub_in = op_a - op_b + p;
      end else begin
         sub_in = op_a - op_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_ctrl[0].valid <= 1'b0;
      end else if (enable) begin
         r_ctrl[0].valid <= ent_ctrl_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         r_ctrl[0].mode <= ent_ctrl_in.mode;
         r_a[0]         <= op_a;
         r_x[0]         <= x_in;
         r_misc[0]      <= sub_in;
      end
   end

   assign r_acc[0] = '0;

   for (genvar k = 1; k <= R; k++) begin : g_red
      mas_reduce_stage #(.N(N), .BIT_POS(N + 1 - k)) u_red (
         .clock    (clock),
         .reset    (reset),
         .enable   (enable),
         .modulus  (p),
         .ctrl_in  (r_ctrl[k-1]),
         .a_in     (r_a[k-1]),
         .x_in     (r_x[k-1]),
         .acc_in   (r_acc[k-1]),
         .misc_in  (r_misc[k-1]),
         .ctrl_out (r_ctrl[k]),
         .a_out    (r_a[k]),
         .x_out    (r_x[k]),
         .acc_out  (r_acc[k]),
         .misc_out (r_misc[k])
      );
   end

   // reduced value becomes b for the multiply, or the add result
   assign m_ctrl[0] = r_ctrl[R];
   assign m_a[0]    = r_a[R];
   assign m_b[0]    = r_acc[R];
   assign m_acc[0]  = '0;
   assign m_misc[0] = (r_ctrl[R].mode == MODE_ADD) ? r_acc[R] : r_misc[R];

   for (genvar j = 1; j <= M; j++) begin : g_mul
      mas_mul_stage #(
         .N       (N),
         .BIT_POS (N - 1 - (j - 1) / 2),
         .HALF    (((j - 1) % 2) == 1)
      ) u_mul (
         .clock    (clock),
         .reset    (reset),
         .enable   (enable),
         .modulus  (p),
         .ctrl_in  (m_ctrl[j-1]),
         .a_in     (m_a[j-1]),
         .b_in     (m_b[j-1]),
         .acc_in   (m_acc[j-1]),
         .misc_in  (m_misc[j-1]),
         .ctrl_out (m_ctrl[j]),
         .a_out    (m_a[j]),
         .b_out    (m_b[j]),
         .acc_out  (m_acc[j]),
         .misc_out (m_misc[j])
      );
   end

   always_comb begin
      rsp_result_in = '0;
      case (m_ctrl[M].mode)
         MODE_ADD: rsp_result_in[N-1:0] = m_misc[M];
         MODE_SUB: rsp_result_in[N-1:0] = m_misc[M];
         MODE_MUL: rsp_result_in[N-1:0] = m_acc[M];
         default:  rsp_result_in        = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= m_ctrl[M].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_result_ff <= rsp_result_in;
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.result = rsp_result_ff;
endmodule

/* rtl/mas_checker.sv */
// Checker: port-level assertions for the modular unit, bound to the top level.
module mas_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [mas_pkg::DATA_BITS-1:0] rsp_result
);
   a_ready_follows_out: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow output stage");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_result))
      else $error("response changed while stalled");
endmodule

bind modular_add_sub_mul_unit_top mas_checker u_mas_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_result (rsp_chan.result)
);
